// ===== rtl/alc_pkg.sv =====
// Shared types, constants and helpers for the ambient light dimmer controller.
package alc_pkg;

	localparam int LUX_W     = 24;
	localparam int TIME_W    = 32;
	localparam int HOUR_W    = 5;
	localparam int LVL_W     = 8;
	localparam int CFG_LVL_W = 7;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 3;
	localparam int ACT_W     = 3;
	localparam int FUNC_W    = 2;
	localparam int TGT_W     = 13;
	localparam int CMP_W     = 26;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 48;

	// event kinds carried on s_tuser
	localparam logic [FUNC_W-1:0] FUNC_LUX    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BUTTON = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE          = 3'd0,
		ACT_SET_LEVEL     = 3'd1,
		ACT_SET_LEVEL_ON  = 3'd2,
		ACT_SWITCH_OFF    = 3'd3,
		ACT_REFRESH_NOW   = 3'd4,
		ACT_REFRESH_LATER = 3'd5
	} action_t;

	localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SWING    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HOLDOFF  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TURN_ON  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MORNING  = 3'd4;

	localparam logic [CFG_W-1:0]     SWING_RST    = 16'd704;
	localparam logic [CFG_W-1:0]     HOLDOFF_RST  = 16'd121;
	localparam logic [CFG_LVL_W-1:0] TURN_ON_RST  = 7'd15;
	localparam logic [CFG_LVL_W-1:0] MORNING_RST  = 7'd20;

	localparam logic [LVL_W-1:0]  LVL_MAX       = 8'd100;
	localparam logic [LVL_W-1:0]  LVL_UP2_LIMIT = 8'd97;
	localparam logic [LVL_W-1:0]  LVL_OFF_LIMIT = 8'd10;
	localparam logic [LVL_W-1:0]  LVL_DN2_LIMIT = 8'd5;
	localparam logic [HOUR_W-1:0] HOUR_EVENING  = 5'd18;
	localparam logic [HOUR_W-1:0] HOUR_MORNING  = 5'd8;
	localparam logic [TIME_W-1:0] REFRESH_DELAY = 32'd4;

	// controller -> datapath
	typedef struct packed {
		logic latch;
		logic load;
		logic div_start;
		logic cmp;
		logic rule;
		logic exec;
		logic out_load;
	} alc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} alc_sts_t;

	// hourly target illuminance, Q8 lux
	function automatic logic [TGT_W-1:0] target_q8(input logic [HOUR_W-1:0] h);
		logic [TGT_W-1:0] t;
		if (h <= 5'd5)       t = 13'd1920;
		else if (h == 5'd6)  t = 13'd3840;
		else if (h == 5'd7)  t = 13'd5120;
		else if (h <= 5'd17) t = 13'd6400;
		else if (h == 5'd18) t = 13'd5120;
		else                 t = 13'd2560;
		return t;
	endfunction

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

// ===== rtl/alc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module alc_div #(
	parameter int DVD_W = 27,
	parameter int DVS_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   shifted;
	logic             ge;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule

// ===== rtl/alc_ctrl.sv =====
// Sequencing state machine for the dimmer controller.
module alc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic [alc_pkg::FUNC_W-1:0] s_tuser,
	output logic                      s_tready,
	input  alc_pkg::alc_sts_t         sts,
	output alc_pkg::alc_cmd_t         cmd
);
	import alc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOAD  = 8'b0000_0010,
		ST_START = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_CMP   = 8'b0001_0000,
		ST_RULE  = 8'b0010_0000,
		ST_EXEC  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = (s_tuser == FUNC_LUX) ? ST_LOAD : ST_EXEC;
			ST_LOAD:  state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV:   if (sts.div_done) state_d = ST_CMP;
			ST_CMP:   state_d = ST_RULE;
			ST_RULE:  state_d = ST_OUT;
			ST_EXEC:  state_d = ST_OUT;
			ST_OUT:   if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign s_tready      = (state_q == ST_IDLE);
	assign cmd.latch     = (state_q == ST_IDLE) && s_tvalid;
	assign cmd.load      = (state_q == ST_LOAD);
	assign cmd.div_start = (state_q == ST_START);
	assign cmd.cmp       = (state_q == ST_DIV) && sts.div_done;
	assign cmd.rule      = (state_q == ST_RULE);
	assign cmd.exec      = (state_q == ST_EXEC);
	assign cmd.out_load  = (state_q == ST_OUT) && sts.out_free;
endmodule

// ===== rtl/alc_datapath.sv =====
// Datapath: configuration, sample window, averaging, control rules and result register.
module alc_datapath #(
	parameter int WINDOW_DEPTH = 6,
	parameter int MIN_SAMPLES  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [alc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [alc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [alc_pkg::FUNC_W-1:0]    s_tuser,
	input  logic [alc_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [alc_pkg::M_TDATA_W-1:0] m_tdata,
	input  alc_pkg::alc_cmd_t             cmd,
	output alc_pkg::alc_sts_t             sts
);
	import alc_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = LUX_W + CNT_W;

	// configuration
	logic                 enable_q;
	logic [CFG_W-1:0]     swing_q;
	logic [CFG_W-1:0]     holdoff_q;
	logic [CFG_LVL_W-1:0] turn_on_q;
	logic [CFG_LVL_W-1:0] morning_q;

	// latched request
	logic [FUNC_W-1:0] func_q;
	logic [TIME_W-1:0] now_q;
	logic [HOUR_W-1:0] hour_q;
	logic [LUX_W-1:0]  lux_q;
	logic [7:0]        btn_q;
	logic [LVL_W-1:0]  rep_q;

	// control state
	logic [LUX_W-1:0]  window_q [WINDOW_DEPTH];
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [LUX_W-1:0]  avg_q;
	logic              light_q;
	logic [LVL_W-1:0]  level_q;
	logic [TIME_W-1:0] holdoff_until_q;

	// registered rule conditions
	logic ok_q, on_q, up_q, up2_q, dn_q, dn2_q;

	action_t           res_act_q;
	logic [TIME_W-1:0] res_ref_q;

	logic              out_valid_q;
	action_t           out_act_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic [TIME_W-1:0] out_ref_q;

	logic             full;
	logic [SUM_W-1:0] quo;
	logic             div_done;

	alc_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign full = (cnt_q == CNT_W'(WINDOW_DEPTH));

	// rule comparisons, widened so average or target plus swing never wraps
	logic [CMP_W-1:0] avg_w, old_w, t_w, s_w, s2_w;
	logic [CMP_W-1:0] as1, as2, ts1, ts2;
	assign avg_w = CMP_W'(quo[LUX_W-1:0]);
	assign old_w = CMP_W'(avg_q);
	assign t_w   = CMP_W'(target_q8(hour_q));
	assign s_w   = CMP_W'(swing_q);
	assign s2_w  = {s_w[CMP_W-2:0], 1'b0};
	assign as1   = avg_w + s_w;
	assign as2   = avg_w + s2_w;
	assign ts1   = t_w + s_w;
	assign ts2   = t_w + s2_w;

	logic [LVL_W-1:0]  up1, dn1;
	logic [TIME_W-1:0] hold_end;
	assign up1      = level_q + 1'b1;
	assign dn1      = level_q - 1'b1;
	assign hold_end = sat_add(now_q, TIME_W'(holdoff_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			swing_q   <= SWING_RST;
			holdoff_q <= HOLDOFF_RST;
			turn_on_q <= TURN_ON_RST;
			morning_q <= MORNING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_wdata[0];
				REG_SWING:   swing_q   <= cfg_wdata;
				REG_HOLDOFF: holdoff_q <= cfg_wdata;
				REG_TURN_ON: turn_on_q <= cfg_wdata[CFG_LVL_W-1:0];
				REG_MORNING: morning_q <= cfg_wdata[CFG_LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= s_tuser;
			now_q  <= s_tdata[31:0];
			hour_q <= s_tdata[36:32];
			lux_q  <= s_tdata[60:37];
			btn_q  <= s_tdata[68:61];
			rep_q  <= s_tdata[76:69];
		end
		// entries at or above the count are never read, so a clear only resets the count
		if (cmd.load) begin
			if (full) begin
				for (int i = 0; i < WINDOW_DEPTH - 1; i++)
					window_q[i] <= window_q[i+1];
				window_q[WINDOW_DEPTH-1] <= lux_q;
			end else begin
				for (int i = 0; i < WINDOW_DEPTH; i++)
					if (cnt_q == CNT_W'(i)) window_q[i] <= lux_q;
			end
		end
		if (cmd.cmp) begin
			ok_q  <= enable_q && (32'(cnt_q) >= MIN_SAMPLES) && (now_q >= holdoff_until_q);
			on_q  <= (hour_q < HOUR_EVENING) && (old_w > t_w) && (avg_w <= t_w);
			up_q  <= as1 < t_w;
			up2_q <= as2 < t_w;
			dn_q  <= avg_w > ts1;
			dn2_q <= avg_w > ts2;
		end
		if (cmd.out_load) begin
			out_act_q <= res_act_q;
			out_lvl_q <= level_q;
			out_ref_q <= res_ref_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q           <= '0;
			sum_q           <= '0;
			avg_q           <= '0;
			light_q         <= 1'b0;
			level_q         <= '0;
			holdoff_until_q <= '0;
			res_act_q       <= ACT_NONE;
			res_ref_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				sum_q <= sum_q - (full ? SUM_W'(window_q[0]) : '0) + SUM_W'(lux_q);
				if (!full) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.cmp) avg_q <= quo[LUX_W-1:0];
			if (cmd.rule) begin
				res_ref_q <= '0;
				res_act_q <= ACT_NONE;
				if (ok_q) begin
					if (!light_q && on_q) begin
						level_q   <= LVL_W'(turn_on_q);
						light_q   <= 1'b1;
						cnt_q     <= '0;
						sum_q     <= '0;
						res_act_q <= ACT_SET_LEVEL_ON;
					end else if (light_q && up_q && level_q < LVL_MAX) begin
						level_q   <= (up2_q && up1 < LVL_UP2_LIMIT) ? up1 + 1'b1 : up1;
						cnt_q     <= '0;
						sum_q     <= '0;
						res_act_q <= ACT_SET_LEVEL;
					end else if (light_q && dn_q) begin
						cnt_q <= '0;
						sum_q <= '0;
						if (level_q > LVL_OFF_LIMIT) begin
							level_q   <= (dn2_q && dn1 > LVL_DN2_LIMIT) ? dn1 - 1'b1 : dn1;
							res_act_q <= ACT_SET_LEVEL;
						end else begin
							level_q   <= '0;
							light_q   <= 1'b0;
							res_act_q <= ACT_SWITCH_OFF;
						end
					end
				end
			end
			if (cmd.exec) begin
				res_ref_q <= '0;
				res_act_q <= ACT_NONE;
				case (func_q)
					FUNC_BUTTON: begin
						light_q <= (btn_q != '0);
						if (enable_q) begin
							cnt_q <= '0;
							sum_q <= '0;
							if (hour_q < HOUR_MORNING && btn_q != '0) begin
								level_q   <= LVL_W'(morning_q);
								res_act_q <= ACT_SET_LEVEL;
							end else begin
								res_act_q <= ACT_REFRESH_NOW;
							end
							if (hold_end > holdoff_until_q) holdoff_until_q <= hold_end;
						end
					end
					FUNC_REPORT: begin
						if (enable_q && rep_q != level_q) begin
							res_act_q <= ACT_REFRESH_LATER;
							res_ref_q <= sat_add(now_q, REFRESH_DELAY);
						end
						level_q <= rep_q;
					end
					default: ;
				endcase
			end
			if (cmd.out_load)      out_valid_q <= 1'b1;
			else if (m_tready)     out_valid_q <= 1'b0;
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_ref_q, out_lvl_q, out_act_q};
endmodule

// ===== rtl/ambient_light_dimmer_controller.sv =====
// A lux sample passes through the load, start, divide, compare, rule and output states
//   before m_tvalid; the divide of the window sum yields one quotient bit per cycle.
// Button events, dimmer reports and unused kinds pass through the exec and output states.
// One request in flight; the next can be accepted the cycle after its result enters
//   the output register, which holds it while m_tready is low.
// arst_n clears window, state and control, and loads register defaults.
module ambient_light_dimmer_controller #(
	parameter int WINDOW_DEPTH = 6,
	parameter int MIN_SAMPLES  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [alc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [alc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now_seconds[31:0], hour[36:32], lux_q8[60:37], button_value[68:61],
	// reported_level[76:69], zero fill
	input  logic [alc_pkg::S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [alc_pkg::FUNC_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// action[2:0], dimmer_level[10:3], refresh_at[42:11], zero fill
	output logic [alc_pkg::M_TDATA_W-1:0] m_tdata
);
	import alc_pkg::*;

	alc_cmd_t cmd;
	alc_sts_t sts;

	alc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	alc_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.MIN_SAMPLES  (MIN_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

// ===== rtl/alc_checker.sv =====
// Port-level assertions for the dimmer controller, bound to the top level.
module alc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [alc_pkg::REG_IDX_W-1:0] cfg_index,
	input logic [alc_pkg::CFG_W-1:0]     cfg_wdata,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [alc_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [alc_pkg::FUNC_W-1:0]    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [alc_pkg::M_TDATA_W-1:0] m_tdata
);
	import alc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
		else $error("action code out of range");

	a_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != ACT_REFRESH_LATER |-> m_tdata[42:11] == '0)
		else $error("refresh time set without deferred refresh");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while one is in flight");
endmodule

bind ambient_light_dimmer_controller alc_checker u_alc_checker (.*);

// ===== verif/ambient_light_dimmer_controller_tb.sv =====
`timescale 1ns / 1ps
// Stream testbench for the ambient light dimmer controller with a built-in predictor.
module ambient_light_dimmer_controller_tb;
	import alc_pkg::*;

	localparam int WIN_DEPTH     = 6;
	localparam int MIN_FILL      = 5;
	localparam int RANDOM_EVENTS = 2000;
	localparam int PHASES        = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [TIME_W-1:0] now;
		logic [HOUR_W-1:0] hour;
		logic [LUX_W-1:0]  lux;
		logic [7:0]        button;
		logic [LVL_W-1:0]  rep;
	} light_event_t;

	typedef struct {
		bit                   is_reg;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     reg_val;
		light_event_t         ev;
	} stim_t;

	typedef struct {
		action_t           act;
		logic [LVL_W-1:0]  level;
		logic [TIME_W-1:0] refresh_at;
	} dimmer_cmd_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_CHOKED, RX_BUSY} rx_pattern_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [FUNC_W-1:0]    s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	ambient_light_dimmer_controller #(
		.WINDOW_DEPTH(WIN_DEPTH),
		.MIN_SAMPLES (MIN_FILL)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// predictor state
	logic                 en_q;
	logic [CFG_W-1:0]     swing_q;
	logic [CFG_W-1:0]     holdoff_q;
	logic [CFG_LVL_W-1:0] turn_on_q;
	logic [CFG_LVL_W-1:0] morning_q;
	logic [LUX_W-1:0]     win [WIN_DEPTH];
	int                   fill;
	logic [26:0]          win_sum;
	logic [LUX_W-1:0]     avg_lux;
	logic                 lamp_on;
	logic [LVL_W-1:0]     lamp_level;
	logic [TIME_W-1:0]    quiet_until;

	stim_t        pending_events [$];
	dimmer_cmd_t  awaited_cmds [$];
	light_event_t cur_ev;
	logic         taken = 1'b0;
	int           mismatches = 0;
	int           queued = 0;
	int           gap_left = 0;
	int           burst_left = 0;
	int           stall_left = 0;
	rx_pattern_t  rx_pattern = RX_OPEN;
	logic [31:0]  clock_s;
	int           plan_swing;
	int unsigned  level_marks [14] = '{0, 5, 6, 7, 10, 11, 12, 95, 96, 97, 98, 99, 100, 255};

	function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		longint unsigned s;
		s = longint'(a) + longint'(b);
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[TIME_W-1:0];
	endfunction

	function automatic int hour_goal(logic [HOUR_W-1:0] h);
		if (h >= 19) return 2560;
		if (h == 18) return 5120;
		if (h >= 8) return 6400;
		if (h == 7) return 5120;
		if (h == 6) return 3840;
		return 1920;
	endfunction

	function automatic void drop_window();
		foreach (win[i]) win[i] = '0;
		fill = 0;
		win_sum = '0;
	endfunction

	function automatic void model_reset();
		en_q = 1'b0;
		swing_q = SWING_RST;
		holdoff_q = HOLDOFF_RST;
		turn_on_q = TURN_ON_RST;
		morning_q = MORNING_RST;
		drop_window();
		avg_lux = '0;
		lamp_on = 1'b0;
		lamp_level = '0;
		quiet_until = '0;
	endfunction

	function automatic void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		case (idx)
			REG_ENABLE:  en_q = v[0];
			REG_SWING:   swing_q = v;
			REG_HOLDOFF: holdoff_q = v;
			REG_TURN_ON: turn_on_q = v[CFG_LVL_W-1:0];
			REG_MORNING: morning_q = v[CFG_LVL_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic action_t lux_rules(light_event_t ev);
		longint old_avg;
		longint a;
		longint t;
		longint s;
		old_avg = avg_lux;
		if (fill >= WIN_DEPTH) begin
			win_sum = win_sum - win[0];
			for (int i = 1; i < WIN_DEPTH; i++)
				win[i-1] = win[i];
			fill = WIN_DEPTH - 1;
		end
		win[fill] = ev.lux;
		fill++;
		win_sum = win_sum + ev.lux;
		avg_lux = win_sum / fill;
		if (!en_q || fill < MIN_FILL || ev.now < quiet_until)
			return ACT_NONE;
		a = avg_lux;
		t = hour_goal(ev.hour);
		s = swing_q;
		if (!lamp_on && ev.hour < HOUR_EVENING && old_avg > t && a <= t) begin
			lamp_level = turn_on_q;
			lamp_on = 1'b1;
			drop_window();
			return ACT_SET_LEVEL_ON;
		end
		if (lamp_on && a + s < t && lamp_level < LVL_MAX) begin
			lamp_level++;
			if (a + 2 * s < t && lamp_level < LVL_UP2_LIMIT)
				lamp_level++;
			drop_window();
			return ACT_SET_LEVEL;
		end
		if (lamp_on && a > t + s) begin
			drop_window();
			if (lamp_level > LVL_OFF_LIMIT) begin
				lamp_level--;
				if (a > t + 2 * s && lamp_level > LVL_DN2_LIMIT)
					lamp_level--;
				return ACT_SET_LEVEL;
			end
			lamp_level = '0;
			lamp_on = 1'b0;
			return ACT_SWITCH_OFF;
		end
		return ACT_NONE;
	endfunction

	function automatic dimmer_cmd_t predict_cmd(light_event_t ev);
		dimmer_cmd_t       c;
		logic [TIME_W-1:0] hold_end;
		c.act = ACT_NONE;
		c.refresh_at = '0;
		case (ev.func)
			FUNC_LUX: c.act = lux_rules(ev);
			FUNC_BUTTON: begin
				lamp_on = (ev.button != 0);
				if (en_q) begin
					drop_window();
					if (ev.hour < HOUR_MORNING && lamp_on) begin
						lamp_level = morning_q;
						c.act = ACT_SET_LEVEL;
					end else
						c.act = ACT_REFRESH_NOW;
					hold_end = add_sat(ev.now, holdoff_q);
					if (hold_end > quiet_until)
						quiet_until = hold_end;
				end
			end
			FUNC_REPORT: begin
				if (en_q && ev.rep != lamp_level) begin
					c.act = ACT_REFRESH_LATER;
					c.refresh_at = add_sat(ev.now, REFRESH_DELAY);
				end
				lamp_level = ev.rep;
			end
			default: ;
		endcase
		c.level = lamp_level;
		return c;
	endfunction

	function automatic void push_event(logic [FUNC_W-1:0] f, logic [31:0] t, logic [31:0] h,
		logic [31:0] lx, logic [31:0] b, logic [31:0] r);
		stim_t st;
		st.is_reg = 1'b0;
		st.reg_idx = '0;
		st.reg_val = '0;
		st.ev.func = f;
		st.ev.now = t;
		st.ev.hour = h[HOUR_W-1:0];
		st.ev.lux = lx[LUX_W-1:0];
		st.ev.button = b[7:0];
		st.ev.rep = r[LVL_W-1:0];
		pending_events.push_back(st);
		if (f != FUNC_UNUSED)
			queued++;
	endfunction

	function automatic void push_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
		stim_t st;
		st.is_reg = 1'b1;
		st.reg_idx = idx;
		st.reg_val = v[CFG_W-1:0];
		st.ev = '{default: '0};
		pending_events.push_back(st);
	endfunction

	function automatic logic [31:0] tick();
		clock_s = clock_s + $urandom_range(1, 40);
		return clock_s;
	endfunction

	function automatic logic [31:0] any_hour();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
	endfunction

	// a run of samples that drifts around the hourly target
	function automatic void queue_lux_run();
		logic [31:0] h;
		int          span;
		int          center;
		int          drift;
		int          len;
		int          v;
		h = any_hour();
		span = plan_swing + 300;
		center = hour_goal(h[HOUR_W-1:0]) + int'($urandom_range(0, 6 * span)) - 3 * span;
		drift = int'($urandom_range(0, span)) - span / 2;
		len = $urandom_range(MIN_FILL, WIN_DEPTH + 3);
		repeat (len) begin
			v = center + int'($urandom_range(0, span)) - span / 2;
			if ($urandom_range(0, 19) == 0)
				v = $urandom_range(0, 1) ? 0 : 24'hFF_FFFF;
			if (v < 0)
				v = 0;
			if (v > 24'hFF_FFFF)
				v = 24'hFF_FFFF;
			push_event(FUNC_LUX, tick(), h, v, $urandom, $urandom);
			center = center + drift;
		end
	endfunction

	// sender: bursts of requests, register writes only with nothing in flight
	always @(negedge clk) begin : drive_events
		stim_t st;
		logic  nxt_valid;
		logic  nxt_we;
		nxt_valid = s_tvalid;
		nxt_we = 1'b0;
		if (arst_n && !(s_tvalid && !taken)) begin
			nxt_valid = 1'b0;
			if (gap_left > 0)
				gap_left--;
			else if (pending_events.size() > 0) begin
				if (pending_events[0].is_reg) begin
					if (awaited_cmds.size() == 0) begin
						nxt_we = 1'b1;
						cfg_index <= pending_events[0].reg_idx;
						cfg_wdata <= pending_events[0].reg_val;
						pending_events.delete(0);
					end
				end else begin
					st = pending_events[0];
					pending_events.delete(0);
					cur_ev <= st.ev;
					s_tdata <= {3'b000, st.ev.rep, st.ev.button, st.ev.lux, st.ev.hour, st.ev.now};
					s_tuser <= st.ev.func;
					nxt_valid = 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
						burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 120);
					end
				end
			end
		end
		s_tvalid <= nxt_valid;
		cfg_we <= nxt_we;
	end

	// receiver: stall pattern is redrawn at random when its run length expires
	always @(negedge clk) begin : stall_results
		if (stall_left == 0) begin
			rx_pattern = rx_pattern_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 400);
		end else
			stall_left--;
		case (rx_pattern)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
			RX_CHOKED: m_tready <= ($urandom_range(0, 9) == 0);
			default:   m_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin : watch_bus
		dimmer_cmd_t want;
		taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we)
				set_reg(cfg_index, cfg_wdata);
			if (m_tvalid && m_tready) begin
				if (awaited_cmds.size() == 0) begin
					$display("%0t: result with no request pending, got %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = awaited_cmds[0];
					awaited_cmds.delete(0);
					if (m_tdata[2:0] !== want.act) begin
						$display("%0t: action expected %0d got %0d", $time, want.act, m_tdata[2:0]);
						mismatches++;
					end
					if (m_tdata[10:3] !== want.level) begin
						$display("%0t: dimmer_level expected %0d got %0d", $time, want.level,
							m_tdata[10:3]);
						mismatches++;
					end
					if (m_tdata[42:11] !== want.refresh_at) begin
						$display("%0t: refresh_at expected %h got %h", $time, want.refresh_at,
							m_tdata[42:11]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				awaited_cmds.push_back(predict_cmd(cur_ev));
		end
	end

	initial begin : stimulus
		int          goal;
		int          pick;
		logic [31:0] sw;
		model_reset();
		clock_s = 32'd1000;
		plan_swing = SWING_RST;

		// disabled: only the average and the on flag move
		push_event(FUNC_LUX, clock_s, 31, 24'hFF_FFFF, 8'hFF, 8'hFF);
		push_event(FUNC_BUTTON, clock_s + 1, 3, 0, 8'h01, 0);
		push_event(FUNC_UNUSED, 32'hFFFF_FFFF, 31, 24'hFF_FFFF, 8'hFF, 8'hFF);
		push_reg(REG_ENABLE, 1);
		// level differs, refresh time saturates; then the same level again
		push_event(FUNC_REPORT, 32'hFFFF_FFFE, 0, 0, 0, 8'hFF);
		push_event(FUNC_REPORT, clock_s + 2, 0, 0, 0, 8'hFF);
		// button off, morning switch-on, switch-on after eight
		push_event(FUNC_BUTTON, clock_s + 3, 3, 0, 8'h00, 0);
		push_event(FUNC_BUTTON, clock_s + 4, 7, 0, 8'h80, 0);
		push_event(FUNC_BUTTON, clock_s + 5, 8, 0, 8'hFF, 0);
		clock_s = clock_s + 200;
		// dark room: double step up
		repeat (5) push_event(FUNC_LUX, tick(), 12, 0, 0, 0);
		// low level and bright room: switch off
		push_event(FUNC_REPORT, tick(), 12, 0, 0, 10);
		repeat (5) push_event(FUNC_LUX, tick(), 12, 40000, 0, 0);
		// average falls onto the target: switch on
		repeat (4) push_event(FUNC_LUX, tick(), 12, 8000, 0, 0);
		push_event(FUNC_LUX, tick(), 12, 0, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: sw = SWING_RST;
				1: sw = 0;
				2: sw = 16'hFFFF;
				default: sw = $urandom_range(0, 2000);
			endcase
			plan_swing = sw;
			push_reg(REG_ENABLE, (p == 5) ? 0 : 1);
			push_reg(REG_SWING, sw);
			push_reg(REG_HOLDOFF, (p == 0) ? HOLDOFF_RST : (p == 1) ? 0 : (p == 3) ? 16'hFFFF :
				$urandom_range(0, 600));
			push_reg(REG_TURN_ON, (p == 1) ? 0 : (p == 2) ? 100 : $urandom_range(0, 100));
			push_reg(REG_MORNING, (p == 1) ? 100 : (p == 2) ? 0 : $urandom_range(0, 100));
			// step past any long hold-off left from the last phase
			clock_s = clock_s + 70000;
			goal = queued + RANDOM_EVENTS / PHASES;
			while (queued < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 62)
					queue_lux_run();
				else if (pick < 72)
					push_event(FUNC_BUTTON, tick(), any_hour(), $urandom,
						($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255), $urandom);
				else if (pick < 84)
					push_event(FUNC_REPORT, tick(), any_hour(), $urandom, $urandom,
						$urandom_range(0, 1) ? level_marks[$urandom_range(0, 13)] :
						$urandom_range(0, 255));
				else if (pick < 86)
					push_event(FUNC_UNUSED, $urandom, $urandom_range(0, 31), $urandom, $urandom,
						$urandom);
				else
					push_event($urandom_range(0, 1) ? FUNC_LUX : FUNC_REPORT, $urandom,
						$urandom_range(0, 31), $urandom, $urandom, $urandom);
			end
		end

		// hold-off end saturates and blocks the rules for good
		push_reg(REG_ENABLE, 1);
		push_reg(REG_HOLDOFF, 16'hFFFF);
		push_event(FUNC_BUTTON, 32'hFFFF_FF00, 12, 0, 8'h01, 0);
		push_event(FUNC_LUX, 32'hFFFF_FFFE, 12, 0, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() != 0 || s_tvalid || awaited_cmds.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/alc_pkg.sv
rtl/alc_div.sv
rtl/alc_ctrl.sv
rtl/alc_datapath.sv
rtl/ambient_light_dimmer_controller.sv
rtl/alc_checker.sv
verif/ambient_light_dimmer_controller_tb.sv
